FILE: hdl/lcdtr_pkg.sv
// lcdtr_pkg: timing constants, register offsets, mode and action codes and
// the request/result structs shared by the lcd timing and register unit
// no dependencies
`default_nettype none

package lcdtr_pkg;

    localparam int DOTS_PER_LINE   = 456;
    localparam int LINES_PER_FRAME = 154;
    localparam int MODE3_DOTS      = 172;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 8;

    localparam logic [DOT_W-1:0]  DOT_LINE_END      = DOT_W'(DOTS_PER_LINE);
    localparam logic [DOT_W-1:0]  OAM_LAST_DOT      = DOT_W'(79);
    localparam logic [DOT_W-1:0]  DRAW_FIRST_DOT    = DOT_W'(80);
    localparam logic [DOT_W-1:0]  DRAW_LAST_DOT     = DOT_W'(MODE3_DOTS + 80 - 1);
    localparam logic [DOT_W-1:0]  HBLANK_FIRST_DOT  = DOT_W'(MODE3_DOTS + 80);
    localparam logic              HBLANK_REACHED    = (MODE3_DOTS + 80) < DOTS_PER_LINE;
    localparam logic [LINE_W-1:0] LINE_FRAME_END    = LINE_W'(LINES_PER_FRAME);
    localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = LINE_W'(143);
    localparam logic [LINE_W-1:0] VBLANK_LINE       = LINE_W'(144);

    localparam logic [7:0] STAT_SRC_MASK = 8'h78;
    localparam logic [7:0] STAT_READ_SET = 8'h80;
    localparam int         LCD_ENABLE_BIT = 7;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_SCY  = 4'd2;
    localparam logic [3:0] REG_SCX  = 4'd3;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_BGP  = 4'd7;
    localparam logic [3:0] REG_OBP0 = 4'd8;
    localparam logic [3:0] REG_OBP1 = 4'd9;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
        logic       stat_pending;
    } t_req;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [1:0]        lcd_mode;
        logic [LINE_W-1:0] line_number;
        logic              vblank_request;
        logic              stat_request;
        logic              sprite_search_now;
        logic              render_line_now;
        logic              frame_done;
    } t_rsp;

endpackage

`default_nettype wire

FILE: hdl/lcdtr_req_if.sv
// lcdtr_req_if: valid/ready channel carrying one request into the unit
// no dependencies
`default_nettype none

interface lcdtr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic       stat_pending;

    modport source(output valid, action, reg_offset, write_data, stat_pending,
                   input ready);
    modport sink(input valid, action, reg_offset, write_data, stat_pending,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/lcdtr_rsp_if.sv
// lcdtr_rsp_if: valid/ready channel carrying one result out of the unit
// no dependencies
`default_nettype none

interface lcdtr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic       vblank_request;
    logic       stat_request;
    logic       sprite_search_now;
    logic       render_line_now;
    logic       frame_done;

    modport source(output valid, read_data, lcd_mode, line_number, vblank_request,
                   stat_request, sprite_search_now, render_line_now, frame_done,
                   input ready);
    modport sink(input valid, read_data, lcd_mode, line_number, vblank_request,
                 stat_request, sprite_search_now, render_line_now, frame_done,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/lcdtr_regs.sv
// lcdtr_regs: register file, dot and line counters and the per-request update
// depends on lcdtr_pkg
`default_nettype none

module lcdtr_regs
    import lcdtr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    logic [7:0]        r_lcdc,  n_lcdc;
    logic [3:0]        r_src,   n_src;
    logic [1:0]        r_mode,  n_mode;
    logic              r_coin,  n_coin;
    logic [7:0]        r_scy,   n_scy;
    logic [7:0]        r_scx,   n_scx;
    logic [LINE_W-1:0] r_line,  n_line;
    logic [7:0]        r_lyc,   n_lyc;
    logic [7:0]        r_bgp,   n_bgp;
    logic [7:0]        r_obp0,  n_obp0;
    logic [7:0]        r_obp1,  n_obp1;
    logic [DOT_W-1:0]  r_dot,   n_dot;
    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W-1:0] line_inc;

    function automatic logic stat_hit(input logic pending, input logic coin,
                                      input logic [1:0] mode, input logic [3:0] src);
        logic hit;
        hit = (coin && src[3]) ||
              (mode == MODE_HBLANK && src[0]) ||
              (mode == MODE_OAM && src[2]) ||
              (mode == MODE_VBLANK && src[1]);
        return !pending && hit;
    endfunction

    assign dot_inc  = r_dot + DOT_W'(1);
    assign line_inc = r_line + LINE_W'(1);

    always_comb begin
        n_lcdc = r_lcdc;
        n_src  = r_src;
        n_mode = r_mode;
        n_coin = r_coin;
        n_scy  = r_scy;
        n_scx  = r_scx;
        n_line = r_line;
        n_lyc  = r_lyc;
        n_bgp  = r_bgp;
        n_obp0 = r_obp0;
        n_obp1 = r_obp1;
        n_dot  = r_dot;
        o_rsp  = '0;
        case (i_req.action)
            ACT_TICK: begin
                if (r_lcdc[LCD_ENABLE_BIT]) begin
                    if (r_line <= LAST_VISIBLE_LINE) begin
                        if (r_dot == '0) begin
                            n_coin = (r_lyc == r_line);
                            o_rsp.stat_request = stat_hit(i_req.stat_pending,
                                                          n_coin, r_mode, r_src);
                            n_mode = MODE_OAM;
                        end
                        o_rsp.sprite_search_now = (r_dot == OAM_LAST_DOT);
                        if (r_dot == DRAW_FIRST_DOT) begin
                            n_mode = MODE_DRAW;
                        end
                        o_rsp.render_line_now = (r_dot == DRAW_LAST_DOT);
                        if (HBLANK_REACHED && r_dot == HBLANK_FIRST_DOT) begin
                            n_mode = MODE_HBLANK;
                        end
                    end else if (r_line == VBLANK_LINE && r_dot == '0) begin
                        n_mode = MODE_VBLANK;
                        o_rsp.vblank_request = 1'b1;
                    end
                    if (dot_inc >= DOT_LINE_END) begin
                        n_dot = '0;
                        if (line_inc >= LINE_FRAME_END) begin
                            n_line = '0;
                            o_rsp.frame_done = 1'b1;
                        end else begin
                            n_line = line_inc;
                        end
                    end else begin
                        n_dot = dot_inc;
                    end
                end
            end
            ACT_READ: begin
                case (i_req.reg_offset)
                    REG_LCDC: o_rsp.read_data = r_lcdc;
                    REG_STAT: o_rsp.read_data = STAT_READ_SET | {1'b0, r_src, r_coin, r_mode};
                    REG_SCY:  o_rsp.read_data = r_scy;
                    REG_SCX:  o_rsp.read_data = r_scx;
                    REG_LY: begin
                        if (!r_lcdc[LCD_ENABLE_BIT]) begin
                            n_line = '0;
                        end else begin
                            o_rsp.read_data = r_line;
                        end
                    end
                    REG_LYC:  o_rsp.read_data = r_lyc;
                    REG_BGP:  o_rsp.read_data = r_bgp;
                    REG_OBP0: o_rsp.read_data = r_obp0;
                    REG_OBP1: o_rsp.read_data = r_obp1;
                    default:  o_rsp.read_data = '0;
                endcase
            end
            ACT_WRITE: begin
                case (i_req.reg_offset)
                    REG_LCDC: n_lcdc = i_req.write_data;
                    REG_STAT: n_src  = 4'((i_req.write_data & STAT_SRC_MASK) >> 3);
                    REG_SCY:  n_scy  = i_req.write_data;
                    REG_SCX:  n_scx  = i_req.write_data;
                    REG_LYC: begin
                        n_lyc  = i_req.write_data;
                        n_coin = (i_req.write_data == r_line);
                        o_rsp.stat_request = stat_hit(i_req.stat_pending,
                                                      n_coin, r_mode, r_src);
                    end
                    REG_BGP:  n_bgp  = i_req.write_data;
                    REG_OBP0: n_obp0 = i_req.write_data;
                    REG_OBP1: n_obp1 = i_req.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        o_rsp.lcd_mode    = n_mode;
        o_rsp.line_number = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0;
            r_src  <= '0;
            r_mode <= MODE_HBLANK;
            r_coin <= 1'b0;
            r_scy  <= '0;
            r_scx  <= '0;
            r_line <= '0;
            r_lyc  <= '0;
            r_bgp  <= '0;
            r_obp0 <= '0;
            r_obp1 <= '0;
            r_dot  <= '0;
        end else if (i_step) begin
            r_lcdc <= n_lcdc;
            r_src  <= n_src;
            r_mode <= n_mode;
            r_coin <= n_coin;
            r_scy  <= n_scy;
            r_scx  <= n_scx;
            r_line <= n_line;
            r_lyc  <= n_lyc;
            r_bgp  <= n_bgp;
            r_obp0 <= n_obp0;
            r_obp1 <= n_obp1;
            r_dot  <= n_dot;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lcd_timing_and_registers.sv
// lcd_timing_and_registers: top level, input request register, result register
// depends on lcdtr_pkg, lcdtr_req_if, lcdtr_rsp_if, lcdtr_regs
//
// usage:
// requests arrive on i_req (dot tick, register read or register write) and one
// result per request leaves on o_rsp, both as valid/ready channels; a request
// is taken at a clock edge where valid and ready are both high
// the request is captured in an input register; when it advances, the
// register file and counters update and the result is loaded into the output
// register, from which the result is offered on o_rsp until it is taken
// throughput is one request per clock: the input register moves on whenever
// the output register is empty or being drained in the same cycle
// when the receiver stalls the result holds in the output register and one
// further request waits in the input register; i_req.ready drops only once
// both are full
// i_rst_n (synchronous, active low) clears the register file, counters and
// both valid flags; the lcd starts switched off with the line counter at zero
`default_nettype none

module lcd_timing_and_registers
    import lcdtr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lcdtr_req_if.sink     i_req,
    lcdtr_rsp_if.source   o_rsp
);

    logic r_req_valid;
    t_req r_req;
    logic r_rsp_valid;
    t_rsp r_rsp;
    t_rsp rsp_next;
    logic advance;

    assign advance     = r_req_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req.action       <= i_req.action;
            r_req.reg_offset   <= i_req.reg_offset;
            r_req.write_data   <= i_req.write_data;
            r_req.stat_pending <= i_req.stat_pending;
        end
    end

    lcdtr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_req),
        .o_rsp   (rsp_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp <= rsp_next;
        end
    end

    assign o_rsp.valid             = r_rsp_valid;
    assign o_rsp.read_data         = r_rsp.read_data;
    assign o_rsp.lcd_mode          = r_rsp.lcd_mode;
    assign o_rsp.line_number       = r_rsp.line_number;
    assign o_rsp.vblank_request    = r_rsp.vblank_request;
    assign o_rsp.stat_request      = r_rsp.stat_request;
    assign o_rsp.sprite_search_now = r_rsp.sprite_search_now;
    assign o_rsp.render_line_now   = r_rsp.render_line_now;
    assign o_rsp.frame_done        = r_rsp.frame_done;

endmodule

`default_nettype wire

FILE: verif/lcd_timing_and_registers_test.sv
// lcd_timing_and_registers_test: self-checking bench for the lcd timing and register unit
// drives requests and checks every result against a cycle-free shadow of the unit
// depends on lcdtr_pkg, lcdtr_req_if, lcdtr_rsp_if and lcd_timing_and_registers
`default_nettype none

module lcd_timing_and_registers_test;
    import lcdtr_pkg::*;

    localparam logic [1:0] ACT_NOP      = 2'd3;
    localparam logic [3:0] REG_LAST_OFF = 4'd15;
    localparam int         SRC_LYC      = 3;
    localparam int         SRC_OAM      = 2;
    localparam int         SRC_VBLANK   = 1;
    localparam int         SRC_HBLANK   = 0;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         RANDOM_ITEMS = 80;
    localparam int         MAX_REPORTS  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcdtr_req_if req_ch();
    lcdtr_rsp_if rsp_ch();

    lcd_timing_and_registers u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the unit state
    logic [7:0] sh_lcdc     = '0;
    logic [3:0] sh_stat_src = '0;
    logic [1:0] sh_mode     = MODE_HBLANK;
    logic       sh_coinc    = 1'b0;
    logic [7:0] sh_scy      = '0;
    logic [7:0] sh_scx      = '0;
    logic [7:0] sh_ly       = '0;
    logic [7:0] sh_lyc      = '0;
    logic [7:0] sh_bgp      = '0;
    logic [7:0] sh_obp0     = '0;
    logic [7:0] sh_obp1     = '0;
    logic [8:0] sh_dot      = '0;

    t_rsp lcd_results_due[$];
    int   fault_count  = 0;
    bit   burst_mode   = 1'b0;
    bit   hold_results = 1'b0;

    function automatic logic stat_source_hit(input logic pending);
        if (pending)
            return 1'b0;
        return (sh_coinc && sh_stat_src[SRC_LYC]) ||
               (sh_mode == MODE_HBLANK && sh_stat_src[SRC_HBLANK]) ||
               (sh_mode == MODE_OAM && sh_stat_src[SRC_OAM]) ||
               (sh_mode == MODE_VBLANK && sh_stat_src[SRC_VBLANK]);
    endfunction

    function automatic t_rsp advance_lcd(input t_req r);
        t_rsp       res;
        logic [7:0] masked;
        res = '0;
        case (r.action)
            ACT_TICK: begin
                if (sh_lcdc[LCD_ENABLE_BIT]) begin
                    if (sh_ly <= LAST_VISIBLE_LINE) begin
                        if (sh_dot == 0) begin
                            sh_coinc = (sh_lyc == sh_ly);
                            res.stat_request = stat_source_hit(r.stat_pending);
                            sh_mode = MODE_OAM;
                        end
                        if (sh_dot == OAM_LAST_DOT)
                            res.sprite_search_now = 1'b1;
                        if (sh_dot == DRAW_FIRST_DOT)
                            sh_mode = MODE_DRAW;
                        if (sh_dot >= DRAW_FIRST_DOT && sh_dot == DRAW_LAST_DOT)
                            res.render_line_now = 1'b1;
                        if (HBLANK_REACHED && sh_dot == HBLANK_FIRST_DOT)
                            sh_mode = MODE_HBLANK;
                    end else if (sh_ly == VBLANK_LINE && sh_dot == 0) begin
                        sh_mode = MODE_VBLANK;
                        res.vblank_request = 1'b1;
                    end
                    sh_dot = sh_dot + 1'b1;
                    if (sh_dot >= DOTS_PER_LINE) begin
                        sh_dot = '0;
                        sh_ly = sh_ly + 1'b1;
                        if (sh_ly >= LINES_PER_FRAME) begin
                            sh_ly = '0;
                            res.frame_done = 1'b1;
                        end
                    end
                end
            end
            ACT_READ: begin
                case (r.reg_offset)
                    REG_LCDC: res.read_data = sh_lcdc;
                    REG_STAT: res.read_data = STAT_READ_SET | {1'b0, sh_stat_src, sh_coinc, sh_mode};
                    REG_SCY:  res.read_data = sh_scy;
                    REG_SCX:  res.read_data = sh_scx;
                    REG_LY: begin
                        if (!sh_lcdc[LCD_ENABLE_BIT])
                            sh_ly = '0;
                        res.read_data = sh_ly;
                    end
                    REG_LYC:  res.read_data = sh_lyc;
                    REG_BGP:  res.read_data = sh_bgp;
                    REG_OBP0: res.read_data = sh_obp0;
                    REG_OBP1: res.read_data = sh_obp1;
                    default:  res.read_data = '0;
                endcase
            end
            ACT_WRITE: begin
                case (r.reg_offset)
                    REG_LCDC: sh_lcdc = r.write_data;
                    REG_STAT: begin
                        masked = r.write_data & STAT_SRC_MASK;
                        sh_stat_src = masked[6:3];
                    end
                    REG_SCY: sh_scy = r.write_data;
                    REG_SCX: sh_scx = r.write_data;
                    REG_LYC: begin
                        sh_lyc = r.write_data;
                        sh_coinc = (sh_lyc == sh_ly);
                        res.stat_request = stat_source_hit(r.stat_pending);
                    end
                    REG_BGP:  sh_bgp = r.write_data;
                    REG_OBP0: sh_obp0 = r.write_data;
                    REG_OBP1: sh_obp1 = r.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.lcd_mode    = sh_mode;
        res.line_number = sh_ly;
        return res;
    endfunction

    task automatic send_req(input logic [1:0] act, input logic [3:0] off,
                            input logic [7:0] data, input logic pend);
        t_req item;
        int   gap;
        item.action       = act;
        item.reg_offset   = off;
        item.write_data   = data;
        item.stat_pending = pend;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.reg_offset   <= off;
        req_ch.write_data   <= data;
        req_ch.stat_pending <= pend;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        lcd_results_due.push_back(advance_lcd(item));
    endtask

    task automatic send_random_item(input bit keep_lcd_on);
        int         pick;
        logic [3:0] off;
        logic [7:0] data;
        logic       pend;
        pick = $urandom_range(0, 99);
        off  = 4'($urandom_range(0, 15));
        data = 8'($urandom);
        pend = 1'($urandom_range(0, 1));
        if (off == REG_LCDC && (keep_lcd_on || $urandom_range(0, 3) != 0))
            data[LCD_ENABLE_BIT] = 1'b1;
        if (pick < 60)
            send_req(ACT_TICK, off, data, pend);
        else if (pick < 80)
            send_req(ACT_READ, off, data, pend);
        else if (pick < 95)
            send_req(ACT_WRITE, off, data, pend);
        else
            send_req(ACT_NOP, off, data, pend);
    endtask

    task automatic test_register_access;
        for (int off = REG_STAT; off <= REG_OBP1; off++) begin
            send_req(ACT_WRITE, 4'(off), 8'hFF, 1'b0);
            send_req(ACT_READ, 4'(off), 8'h00, 1'b0);
        end
        send_req(ACT_READ, REG_LAST_OFF, 8'hFF, 1'b1);
        // lyc match with and without a request already pending
        send_req(ACT_WRITE, REG_LYC, 8'h00, 1'b1);
        send_req(ACT_WRITE, REG_LYC, 8'h00, 1'b0);
        send_req(ACT_WRITE, REG_LCDC, 8'hFF, 1'b0);
        send_req(ACT_NOP, REG_LAST_OFF, 8'hFF, 1'b1);
        send_req(ACT_TICK, REG_LCDC, 8'h00, 1'b0);
        send_req(ACT_READ, REG_LY, 8'h00, 1'b0);
        send_req(ACT_WRITE, REG_LCDC, 8'h00, 1'b0);
        send_req(ACT_TICK, REG_LCDC, 8'h00, 1'b0);
        send_req(ACT_READ, REG_LY, 8'h00, 1'b0);
    endtask

    task automatic test_line_timing;
        send_req(ACT_WRITE, REG_STAT, 8'h78, 1'b0);
        send_req(ACT_WRITE, REG_LYC, 8'h01, 1'b0);
        send_req(ACT_WRITE, REG_LCDC, 8'h91, 1'b0);
        for (int i = 0; i < DOTS_PER_LINE + 8; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_req(ACT_READ, ($urandom_range(0, 1) != 0) ? REG_STAT : REG_LY, 8'h00, 1'b0);
            send_req(ACT_TICK, 4'($urandom_range(0, 15)), 8'($urandom),
                     $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_result_backpressure;
        hold_results = 1'b1;
        burst_mode   = 1'b1;
        for (int i = 0; i < 40; i++)
            send_random_item(1'b1);
        burst_mode = 1'b0;
    endtask

    task automatic test_random_mix;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random_item(1'b0);
    endtask

    // result side: random hold-offs plus one long stall on request
    initial begin : result_sink
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_rsp seen;
        t_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_data         = rsp_ch.read_data;
            seen.lcd_mode          = rsp_ch.lcd_mode;
            seen.line_number       = rsp_ch.line_number;
            seen.vblank_request    = rsp_ch.vblank_request;
            seen.stat_request      = rsp_ch.stat_request;
            seen.sprite_search_now = rsp_ch.sprite_search_now;
            seen.render_line_now   = rsp_ch.render_line_now;
            seen.frame_done        = rsp_ch.frame_done;
            if (lcd_results_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result rd=%h mode=%0d ly=%0d", seen.read_data,
                             seen.lcd_mode, seen.line_number);
            end else begin
                want = lcd_results_due.pop_front();
                if (seen !== want) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"mismatch rd/mode/ly/vbl/stat/spr/rnd/frm ",
                                  "expected %h %0d %0d %b %b %b %b %b ",
                                  "actual %h %0d %0d %b %b %b %b %b"},
                                 want.read_data, want.lcd_mode, want.line_number,
                                 want.vblank_request, want.stat_request,
                                 want.sprite_search_now, want.render_line_now,
                                 want.frame_done, seen.read_data, seen.lcd_mode,
                                 seen.line_number, seen.vblank_request, seen.stat_request,
                                 seen.sprite_search_now, seen.render_line_now,
                                 seen.frame_done);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** lcd_timing_and_registers: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ACT_TICK;
        req_ch.reg_offset   <= REG_LCDC;
        req_ch.write_data   <= 8'h00;
        req_ch.stat_pending <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_line_timing();
        test_result_backpressure();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (lcd_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && lcd_results_due.size() == 0)
            $display("** lcd_timing_and_registers: PASSED **");
        else
            $display("** lcd_timing_and_registers: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
